>>> design/kvd_pkg.sv
// Shared types and codes for the keyed tableau Vigenere decrypt unit.
// No dependencies; the top level, kvd_search and kvd_chk import this package.
`default_nettype none

package kvd_pkg;

	localparam int CHAR_W = 8;

	typedef enum logic [1:0] {
		FUNC_TAB  = 2'd0,
		FUNC_KEY  = 2'd1,
		FUNC_DEC  = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	// start of one tableau search, with the key and cipher characters
	typedef struct packed {
		logic              start;
		logic [CHAR_W-1:0] kc;
		logic [CHAR_W-1:0] ch;
	} kvd_req_t;

	// search status and finished result
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [CHAR_W-1:0] plain;
		logic              hit;
	} kvd_stat_t;

endpackage

`default_nettype wire

>>> design/keyed_tableau_vigenere_decrypt_unit.sv
// Top level of the keyed tableau Vigenere decrypt unit: load decode, key
// state, tableau and key RAMs, result register. Uses kvd_pkg, kvd_ram, kvd_search.
//
//   channel | valid     | stall     | payload
//   input   | in_valid  | in_stall  | func, slot_index, char_value, key_final
//   output  | out_valid | out_stall | plain_char, matched
//
// A decrypt takes one key RAM read, then one tableau read per cycle over up
// to ALPHABET_SIZE row heads and up to ALPHABET_SIZE row entries, then one
// read of the first row, all through the single tableau read port.
// in_stall is high while a decrypt is in flight. A stalled result waits in
// the output register while the next item is taken. Reset clears key length
// to one and key position to zero; the RAMs are not cleared.
`default_nettype none

module keyed_tableau_vigenere_decrypt_unit #(
	parameter int ALPHABET_SIZE  = 26,
	parameter int MAX_KEY_LENGTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] func,
	input  wire logic [9:0] slot_index,
	input  wire logic [7:0] char_value,
	input  wire logic       key_final,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic      [7:0] plain_char,
	output logic            matched
);
	import kvd_pkg::*;

	localparam int TDEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
	localparam int TAW = $clog2(TDEPTH);
	localparam int KAW = (MAX_KEY_LENGTH > 1) ? $clog2(MAX_KEY_LENGTH) : 1;
	localparam int KLW = $clog2(MAX_KEY_LENGTH + 1);
	localparam logic [31:0] TDEPTH_W = 32'(TDEPTH);
	localparam logic [31:0] KDEPTH_W = 32'(MAX_KEY_LENGTH);

	logic              in_acc;
	logic              tab_we;
	logic              key_we;
	logic              dec_go;
	logic              tab_re;
	logic [TAW-1:0]    tab_raddr;
	logic [CHAR_W-1:0] tab_rdata;
	logic [CHAR_W-1:0] key_rdata;
	kvd_req_t          req;
	kvd_stat_t         stat;
	logic              take;
	logic [KLW-1:0]    pos_inc;

	logic [KLW-1:0]    key_len_q;
	logic [KAW-1:0]    key_pos_q;
	logic              key_rd_s1;
	logic [CHAR_W-1:0] ch_s1;
	logic              out_vld_q;
	logic [CHAR_W-1:0] plain_q;
	logic              matched_q;

	assign in_stall = key_rd_s1 || stat.busy;
	assign in_acc   = in_valid && !in_stall;
	assign tab_we   = in_acc && (func == FUNC_TAB) && (32'(slot_index) < TDEPTH_W);
	assign key_we   = in_acc && (func == FUNC_KEY) && (32'(slot_index) < KDEPTH_W);
	assign dec_go   = in_acc && (func == FUNC_DEC);
	assign pos_inc  = KLW'(key_pos_q) + 1'b1;

	kvd_ram #(.WIDTH(CHAR_W), .DEPTH(TDEPTH)) u_tab_ram (
		.clk  (clk),
		.we   (tab_we),
		.waddr(TAW'(slot_index)),
		.wdata(char_value),
		.re   (tab_re),
		.raddr(tab_raddr),
		.rdata(tab_rdata)
	);

	kvd_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_KEY_LENGTH)) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(KAW'(slot_index)),
		.wdata(char_value),
		.re   (dec_go),
		.raddr(key_pos_q),
		.rdata(key_rdata)
	);

	assign req.start = key_rd_s1;
	assign req.kc    = key_rdata;
	assign req.ch    = ch_s1;

	// move the result out once the output register is free
	assign take = stat.done && (!out_vld_q || !out_stall);

	kvd_search #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.take     (take),
		.tab_re   (tab_re),
		.tab_raddr(tab_raddr),
		.tab_rdata(tab_rdata),
		.stat     (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= KLW'(1);
			key_pos_q <= '0;
			key_rd_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			key_rd_s1 <= dec_go;
			if (key_we && key_final) begin
				key_len_q <= KLW'(slot_index) + 1'b1;
				key_pos_q <= '0;
			end else if (dec_go) begin
				// advance and wrap at the key length
				key_pos_q <= (pos_inc == key_len_q) ? '0 : KAW'(pos_inc);
			end
			if (take) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dec_go) begin
			ch_s1 <= char_value;
		end
		if (take) begin
			plain_q   <= stat.plain;
			matched_q <= stat.hit;
		end
	end

	assign out_valid  = out_vld_q;
	assign plain_char = plain_q;
	assign matched    = matched_q;

endmodule

`default_nettype wire

>>> design/kvd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependencies.
`default_nettype none

module kvd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/kvd_search.sv
// Tableau search sequencer: scans row heads, then the matching row, then
// reads the first-row byte of the matching column. Uses kvd_pkg types.
`default_nettype none

module kvd_search #(
	parameter int ALPHABET_SIZE = 26,
	localparam int TDEPTH = ALPHABET_SIZE * ALPHABET_SIZE,
	localparam int TAW = $clog2(TDEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire kvd_pkg::kvd_req_t           req,
	input  wire logic                        take,
	output logic                             tab_re,
	output logic      [TAW-1:0]              tab_raddr,
	input  wire logic [kvd_pkg::CHAR_W-1:0]  tab_rdata,
	output kvd_pkg::kvd_stat_t               stat
);
	import kvd_pkg::*;

	localparam int CW = $clog2(ALPHABET_SIZE + 1);
	localparam logic [CW-1:0] CNT_END  = CW'(ALPHABET_SIZE);
	localparam logic [CW-1:0] CNT_LAST = CW'(ALPHABET_SIZE - 1);
	localparam logic [TAW-1:0] ROW_STEP = TAW'(ALPHABET_SIZE);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_ROW  = 6'b000010,
		S_COL  = 6'b000100,
		S_HEAD = 6'b001000,
		S_PLN  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t            state_q;
	logic [CHAR_W-1:0] kc_q;
	logic [CHAR_W-1:0] ch_q;
	logic [CW-1:0]     iss_cnt_q;
	logic [TAW-1:0]    iss_addr_q;
	logic              rd_vld_s1;
	logic [CW-1:0]     rd_cnt_s1;
	logic [TAW-1:0]    rd_addr_s1;
	logic [CHAR_W-1:0] plain_q;
	logic              hit_q;

	logic scanning;
	logic issue;
	logic row_hit;
	logic col_hit;
	logic last_rd;

	assign scanning = (state_q == S_ROW) || (state_q == S_COL);
	assign issue    = scanning && (iss_cnt_q != CNT_END);
	assign row_hit  = (state_q == S_ROW) && rd_vld_s1 && (tab_rdata == kc_q);
	assign col_hit  = (state_q == S_COL) && rd_vld_s1 && (tab_rdata == ch_q);
	assign last_rd  = scanning && rd_vld_s1 && (rd_cnt_s1 == CNT_LAST);

	assign tab_re    = issue || (state_q == S_HEAD);
	assign tab_raddr = iss_addr_q;

	assign stat.busy  = (state_q != S_IDLE);
	assign stat.done  = (state_q == S_DONE);
	assign stat.plain = plain_q;
	assign stat.hit   = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_vld_s1 <= 1'b0;
		end else begin
			// drop the read issued in the cycle that leaves a scan
			rd_vld_s1 <= issue && !row_hit && !col_hit && !last_rd;
			case (state_q)
				S_IDLE: begin
					if (req.start) begin
						state_q <= S_ROW;
					end
				end
				S_ROW: begin
					if (row_hit) begin
						state_q <= S_COL;
					end else if (last_rd) begin
						state_q <= S_DONE;
					end
				end
				S_COL: begin
					if (col_hit) begin
						state_q <= S_HEAD;
					end else if (last_rd) begin
						state_q <= S_DONE;
					end
				end
				S_HEAD: state_q <= S_PLN;
				S_PLN:  state_q <= S_DONE;
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_cnt_s1  <= iss_cnt_q;
		rd_addr_s1 <= iss_addr_q;
		if (state_q == S_IDLE && req.start) begin
			kc_q       <= req.kc;
			ch_q       <= req.ch;
			iss_cnt_q  <= '0;
			iss_addr_q <= '0;
			plain_q    <= '0;
			hit_q      <= 1'b0;
		end else if (row_hit) begin
			// restart the scan along the matching row
			iss_cnt_q  <= '0;
			iss_addr_q <= rd_addr_s1;
		end else if (col_hit) begin
			iss_addr_q <= TAW'(rd_cnt_s1);
		end else if (issue) begin
			iss_cnt_q  <= iss_cnt_q + 1'b1;
			iss_addr_q <= iss_addr_q + ((state_q == S_ROW) ? ROW_STEP : TAW'(1));
		end
		if (state_q == S_PLN) begin
			plain_q <= tab_rdata;
			hit_q   <= 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> design/kvd_chk.sv
// Port-level checker for the keyed tableau Vigenere decrypt unit, bound to
// the top level. Uses kvd_pkg function codes.
`default_nettype none

module kvd_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [1:0] func,
	input wire logic [9:0] slot_index,
	input wire logic [7:0] char_value,
	input wire logic       key_final,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] plain_char,
	input wire logic       matched
);
	import kvd_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(plain_char) && $stable(matched))
		else $error("stalled result changed");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !matched |-> plain_char == 8'd0)
		else $error("unmatched result carries a nonzero character");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func != FUNC_DEC && !out_valid |=> !out_valid)
		else $error("load item produced a result");

	a_dec_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == FUNC_DEC |=> in_stall)
		else $error("input not held off during a decrypt");

endmodule

bind keyed_tableau_vigenere_decrypt_unit kvd_chk u_kvd_chk (.*);

`default_nettype wire
